// ----- rtl/smt_pkg.sv -----
// ----------------------------------------------------------------------------
// smt_pkg: shared types and codes for the set membership table
// Holds the probe word passed along the cell chain, the commit command
// broadcast to all cells, and the operation codes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smt_pkg;

   localparam int ValueWidth = 32;
   localparam int CountWidth = 5;

   // operation codes
   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   // probe word travelling down the chain, one cell per cycle
   typedef struct packed {
      logic                  active;
      logic [ValueWidth-1:0] value;
      logic                  hit;   // some earlier cell holds the value
      logic                  free;  // some earlier cell is empty
   } probe_type;

   // commit command, broadcast to every cell at the end of a scan
   typedef struct packed {
      logic insert;
      logic remove;
   } commit_type;

endpackage

// ----- rtl/set_membership_table.sv -----
// ----------------------------------------------------------------------------
// set_membership_table: bounded set of distinct 32-bit values
// The probe word crosses the chain of CAPACITY cells at one cell per cycle;
// the scan result is then registered, and the response is raised once free.
// One operation at a time: a new word is accepted only in the idle state.
// Reset empties the set at once (valid marks cleared); no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_membership_table #(
   parameter int CAPACITY = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [1:0]                           req_mode,
   input  logic signed [smt_pkg::ValueWidth-1:0] req_element_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_success,
   output logic                                 rsp_full_reject,
   output logic [smt_pkg::CountWidth-1:0]       rsp_element_count,
   output logic                                 rsp_is_empty
);

   localparam int CntW = $clog2(CAPACITY + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [1:0]          mode_ff, mode_in;
   logic                hit_ff, hit_in;
   logic                free_ff, free_in;
   logic [CntW-1:0]     count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                success_ff, success_in;
   logic                full_ff, full_in;
   logic [CntW-1:0]     rsp_count_ff, rsp_count_in;
   logic                accept;
   logic                rsp_free;

   smt_pkg::probe_type  chain [0:CAPACITY];
   smt_pkg::commit_type cmt;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_free  = ~rsp_valid_ff | rsp_ready;

   always_comb begin
      chain[0].active = accept;
      chain[0].value  = req_element_value;
      chain[0].hit    = 1'b0;
      chain[0].free   = 1'b0;
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      smt_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .probe_in  (chain[i]),
         .commit    (cmt),
         .probe_out (chain[i+1])
      );
   end

   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      success_in   = success_ff;
      full_in      = full_ff;
      rsp_count_in = rsp_count_ff;
      cmt.insert   = 1'b0;
      cmt.remove   = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               mode_in  = req_mode;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chain[CAPACITY].active) begin
               hit_in   = chain[CAPACITY].hit;
               free_in  = chain[CAPACITY].free;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               success_in = 1'b0;
               full_in    = 1'b0;
               priority if (mode_ff == smt_pkg::OP_INSERT) begin
                  if (!hit_ff) begin
                     if (free_ff) begin
                        cmt.insert = 1'b1;
                        success_in = 1'b1;
                        count_in   = CntW'(count_ff + 1'b1);
                     end else begin
                        full_in = 1'b1;
                     end
                  end
               end else if (mode_ff == smt_pkg::OP_REMOVE) begin
                  if (hit_ff) begin
                     cmt.remove = 1'b1;
                     success_in = 1'b1;
                     count_in   = CntW'(count_ff - 1'b1);
                  end
               end else if (mode_ff == smt_pkg::OP_LOOKUP) begin
                  success_in = hit_ff;
               end else begin
                  // unused code: no change, report current count
                  success_in = 1'b0;
               end
               rsp_count_in = count_in;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      success_ff   <= success_in;
      full_ff      <= full_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_success       = success_ff;
   assign rsp_full_reject   = full_ff;
   assign rsp_element_count = smt_pkg::CountWidth'(rsp_count_ff);
   assign rsp_is_empty      = (rsp_count_ff == '0);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(CAPACITY))
      else $error("element count exceeds capacity");

   a_probe_exit_in_scan: assert property (@(posedge clock) disable iff (reset)
      chain[CAPACITY].active |-> (state_ff == S_SCAN))
      else $error("probe left the chain outside a scan");

   a_commit_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmt.insert && cmt.remove))
      else $error("insert and remove committed together");

   a_accept_starts_scan: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == S_SCAN))
      else $error("accepted word did not start a scan");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE))
      else $error("response raised outside the done step");

endmodule

// ----- rtl/smt_cell.sv -----
// ----------------------------------------------------------------------------
// smt_cell: one entry of the set membership table
// Holds a value and its valid mark, compares the passing probe word,
// remembers whether it is the matching or the chosen free entry, and
// applies the broadcast commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smt_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  smt_pkg::probe_type     probe_in,
   input  smt_pkg::commit_type    commit,
   output smt_pkg::probe_type     probe_out
);

   logic [smt_pkg::ValueWidth-1:0] value_ff, value_in;
   logic                           valid_ff, valid_in;
   logic                           hit_mark_ff, hit_mark_in;
   logic                           free_mark_ff, free_mark_in;
   smt_pkg::probe_type             probe_ff, probe_in_nx;
   logic                           match;

   assign match = valid_ff && (value_ff == probe_in.value);

   always_comb begin
      probe_in_nx        = probe_in;
      probe_in_nx.hit    = probe_in.hit | match;
      probe_in_nx.free   = probe_in.free | ~valid_ff;

      value_in     = value_ff;
      valid_in     = valid_ff;
      hit_mark_in  = hit_mark_ff;
      free_mark_in = free_mark_ff;

      if (probe_in.active) begin
         hit_mark_in  = match;
         // only the lowest empty entry claims the probe
         free_mark_in = ~valid_ff & ~probe_in.free;
         if (~valid_ff & ~probe_in.free) begin
            value_in = probe_in.value;
         end
      end

      if (commit.insert && free_mark_ff) begin
         valid_in = 1'b1;
      end
      if (commit.remove && hit_mark_ff) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff        <= 1'b0;
         hit_mark_ff     <= 1'b0;
         free_mark_ff    <= 1'b0;
         probe_ff.active <= 1'b0;
      end else begin
         valid_ff        <= valid_in;
         hit_mark_ff     <= hit_mark_in;
         free_mark_ff    <= free_mark_in;
         probe_ff.active <= probe_in_nx.active;
      end
      value_ff       <= value_in;
      probe_ff.value <= probe_in_nx.value;
      probe_ff.hit   <= probe_in_nx.hit;
      probe_ff.free  <= probe_in_nx.free;
   end

   assign probe_out = probe_ff;

endmodule

// ----- tb/sv/set_membership_table_tb.sv -----
// ----------------------------------------------------------------------------
// set_membership_table_tb: self-checking bench for the set membership table
// Streams insert, remove and lookup words (and the unused code) through the
// request channel, mirrors the table contents in a scoreboard class and
// checks every response field in order. Sender bursts and receiver stalls
// are randomized; random phases cycle through filling, draining and mixing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

typedef struct packed {
   logic                           success;
   logic                           full_reject;
   logic [smt_pkg::CountWidth-1:0] element_count;
   logic                           is_empty;
} op_outcome_type;

class set_mirror;
   localparam int Depth = 16;

   logic [smt_pkg::ValueWidth-1:0] slot_value[Depth];
   bit                             slot_used[Depth];
   int unsigned                    held;
   op_outcome_type                 outcome_q[$];
   int unsigned                    mismatches;
   int unsigned                    op_seen[4];
   int unsigned                    hits;
   int unsigned                    full_refusals;
   int unsigned                    peak;

   function new();
      for (int i = 0; i < Depth; i++) slot_used[i] = 1'b0;
      held = 0;
      mismatches = 0;
      hits = 0;
      full_refusals = 0;
      peak = 0;
      for (int i = 0; i < 4; i++) op_seen[i] = 0;
   endfunction

   function int pending();
      return outcome_q.size();
   endfunction

   task report(input string what);
      mismatches++;
      if (mismatches <= 20) $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   // apply one accepted word to the mirrored table and queue its outcome
   function void note_request(input logic [1:0] mode,
                              input logic [smt_pkg::ValueWidth-1:0] value);
      int             hit_slot;
      int             free_slot;
      op_outcome_type o;
      hit_slot = -1;
      free_slot = -1;
      for (int i = 0; i < Depth; i++) begin
         if (slot_used[i] && slot_value[i] == value && hit_slot < 0) hit_slot = i;
         if (!slot_used[i] && free_slot < 0) free_slot = i;
      end
      o = '0;
      case (mode)
         smt_pkg::OP_INSERT: begin
            // a duplicate is refused silently, even into a full table
            if (hit_slot < 0) begin
               if (free_slot < 0) begin
                  o.full_reject = 1'b1;
                  full_refusals++;
               end else begin
                  slot_value[free_slot] = value;
                  slot_used[free_slot] = 1'b1;
                  held++;
                  o.success = 1'b1;
               end
            end
         end
         smt_pkg::OP_REMOVE: begin
            if (hit_slot >= 0) begin
               slot_used[hit_slot] = 1'b0;
               held--;
               o.success = 1'b1;
            end
         end
         smt_pkg::OP_LOOKUP: o.success = (hit_slot >= 0);
         default: ;
      endcase
      if (o.success) hits++;
      if (held > peak) peak = held;
      op_seen[mode]++;
      o.element_count = held[smt_pkg::CountWidth-1:0];
      o.is_empty = (held == 0);
      outcome_q.push_back(o);
   endfunction

   task check_response(input logic s, input logic f,
                       input logic [smt_pkg::CountWidth-1:0] c, input logic e);
      op_outcome_type want;
      if (outcome_q.size() == 0) begin
         report($sformatf("response with none pending (s=%b f=%b c=%0d e=%b)",
                          s, f, c, e));
         return;
      end
      want = outcome_q.pop_front();
      if (s !== want.success)
         report($sformatf("success %b, want %b", s, want.success));
      if (f !== want.full_reject)
         report($sformatf("full_reject %b, want %b", f, want.full_reject));
      if (c !== want.element_count)
         report($sformatf("element_count %0d, want %0d", c, want.element_count));
      if (e !== want.is_empty)
         report($sformatf("is_empty %b, want %b", e, want.is_empty));
   endtask
endclass

module set_membership_table_tb;

   localparam int          TableDepth  = 16;
   localparam int          RandomWords = 1430;
   localparam int          PoolSize    = 24;
   localparam int          CycleLimit  = 600000;
   localparam logic [1:0]  OP_UNUSED   = 2'd3;
   localparam int          PhaseFill   = 0;
   localparam int          PhaseDrain  = 1;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic [1:0]                            req_mode = smt_pkg::OP_LOOKUP;
   logic signed [smt_pkg::ValueWidth-1:0] req_element_value = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic                                  rsp_success;
   logic                                  rsp_full_reject;
   logic [smt_pkg::CountWidth-1:0]        rsp_element_count;
   logic                                  rsp_is_empty;

   set_mirror                      mirror;
   logic [smt_pkg::ValueWidth-1:0] value_pool[PoolSize];
   int unsigned                    words_sent = 0;
   int unsigned                    words_checked = 0;
   int unsigned                    cycle_count = 0;
   int unsigned                    burst_left = 0;
   bit                             steady = 1'b0;
   int unsigned                    stall_run = 0;
   int unsigned                    stall_style = 0;

   set_membership_table #(
      .CAPACITY(TableDepth)
   ) u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_element_value(req_element_value),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_success      (rsp_success),
      .rsp_full_reject  (rsp_full_reject),
      .rsp_element_count(rsp_element_count),
      .rsp_is_empty     (rsp_is_empty)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("** set_membership_table: FAILED **");
         $finish;
      end
   end

   // receiver: stretches of steady ready, random stalls and long holds
   always @(posedge clock) begin
      if (stall_run == 0) begin
         stall_style = $urandom_range(0, 3);
         stall_run = $urandom_range(20, 200);
      end
      stall_run--;
      case (stall_style)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= ($urandom_range(0, 3) == 0);
         default: rsp_ready <= ((stall_run % 48) >= 36);
      endcase
   end

   // response is checked before the word accepted at the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            mirror.check_response(rsp_success, rsp_full_reject, rsp_element_count,
                                  rsp_is_empty);
            words_checked++;
         end
         if (req_valid && req_ready) mirror.note_request(req_mode, req_element_value);
      end
   end

   task send_word(input logic [1:0] mode, input logic [smt_pkg::ValueWidth-1:0] value);
      req_valid <= 1'b1;
      req_mode <= mode;
      req_element_value <= value;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task idle_cycles(input int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task paced_send(input logic [1:0] mode, input logic [smt_pkg::ValueWidth-1:0] value);
      if (burst_left == 0) begin
         if (!steady) idle_cycles($urandom_range(1, 25));
         burst_left = $urandom_range(1, 16);
      end
      burst_left--;
      send_word(mode, value);
   endtask

   task wait_for_responses();
      req_valid <= 1'b0;
      while (words_checked < words_sent) @(posedge clock);
   endtask

   function logic [smt_pkg::ValueWidth-1:0] pick_value();
      if ($urandom_range(0, 99) < 85) return value_pool[$urandom_range(0, PoolSize - 1)];
      return $urandom;
   endfunction

   function logic [1:0] pick_mode(input int kind);
      int unsigned r;
      int unsigned ins_cut;
      int unsigned rem_cut;
      r = $urandom_range(0, 99);
      case (kind)
         PhaseFill:  begin ins_cut = 70; rem_cut = 80; end
         PhaseDrain: begin ins_cut = 15; rem_cut = 75; end
         default:    begin ins_cut = 35; rem_cut = 65; end
      endcase
      if (r < ins_cut) return smt_pkg::OP_INSERT;
      if (r < rem_cut) return smt_pkg::OP_REMOVE;
      if (r < 95) return smt_pkg::OP_LOOKUP;
      return OP_UNUSED;
   endfunction

   initial begin
      int unsigned total;
      int unsigned phase;
      int unsigned len;
      int          kind;

      mirror = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: empty table, extremes, duplicates, misses, unused code
      steady = 1'b1;
      send_word(smt_pkg::OP_LOOKUP, 32'h0000_0000);
      send_word(smt_pkg::OP_REMOVE, 32'h0000_0005);
      send_word(OP_UNUSED,          32'hffff_ffff);
      send_word(smt_pkg::OP_INSERT, 32'h8000_0000);
      send_word(smt_pkg::OP_INSERT, 32'h7fff_ffff);
      send_word(smt_pkg::OP_INSERT, 32'h0000_0000);
      send_word(smt_pkg::OP_INSERT, 32'hffff_ffff);
      send_word(smt_pkg::OP_INSERT, 32'h8000_0000);
      send_word(smt_pkg::OP_LOOKUP, 32'h7fff_ffff);
      send_word(smt_pkg::OP_LOOKUP, 32'h7fff_fffe);
      send_word(smt_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(smt_pkg::OP_REMOVE, 32'h0000_0000);
      send_word(OP_UNUSED,          32'h8000_0000);
      // freed slot gets reused by the next insert
      send_word(smt_pkg::OP_INSERT, 32'h5555_5555);
      send_word(smt_pkg::OP_INSERT, 32'haaaa_aaaa);
      send_word(smt_pkg::OP_LOOKUP, 32'h5555_5555);
      send_word(smt_pkg::OP_REMOVE, 32'h8000_0000);
      send_word(smt_pkg::OP_REMOVE, 32'h7fff_ffff);
      send_word(smt_pkg::OP_REMOVE, 32'hffff_ffff);
      send_word(smt_pkg::OP_REMOVE, 32'h5555_5555);
      send_word(smt_pkg::OP_REMOVE, 32'haaaa_aaaa);
      send_word(smt_pkg::OP_LOOKUP, 32'haaaa_aaaa);

      // random: fill toward capacity, drain, mix; pool keeps hits frequent
      total = 0;
      phase = 0;
      while (total < RandomWords) begin
         kind = phase % 3;
         if (kind == PhaseFill) begin
            for (int i = 0; i < PoolSize; i++) value_pool[i] = $urandom;
            value_pool[0] = 32'h8000_0000;
            value_pool[1] = 32'h7fff_ffff;
         end
         steady = ($urandom_range(0, 3) == 0);
         len = $urandom_range(60, 140);
         if (len > RandomWords - total) len = RandomWords - total;
         for (int k = 0; k < len; k++) paced_send(pick_mode(kind), pick_value());
         total += len;
         if (phase == 0 || $urandom_range(0, 2) == 0) wait_for_responses();
         phase++;
      end

      wait_for_responses();
      repeat (TableDepth + 8) @(posedge clock);
      if (mirror.pending() != 0)
         mirror.report($sformatf("%0d responses never arrived", mirror.pending()));

      $display("covered %0d words: %0d insert, %0d remove, %0d lookup, %0d unused code",
               words_sent, mirror.op_seen[smt_pkg::OP_INSERT],
               mirror.op_seen[smt_pkg::OP_REMOVE], mirror.op_seen[smt_pkg::OP_LOOKUP],
               mirror.op_seen[OP_UNUSED]);
      $display("%0d successes, %0d inserts refused on a full table, peak fill %0d of %0d",
               mirror.hits, mirror.full_refusals, mirror.peak, TableDepth);
      if (mirror.mismatches == 0) begin
         $display("** set_membership_table: PASSED **");
      end else begin
         $display("%0d mismatches", mirror.mismatches);
         $display("** set_membership_table: FAILED **");
      end
      $finish;
   end

endmodule

// ----- set_membership_table.f -----
rtl/smt_pkg.sv
rtl/smt_cell.sv
rtl/set_membership_table.sv
tb/sv/set_membership_table_tb.sv
